// ===== rtl/core/octt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package octt_pkg;

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_TICK     = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_REGISTERED = 2'd0,
    KIND_FULL       = 2'd1,
    KIND_FIRED      = 2'd2,
    KIND_NONE       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] start_count;
    logic [15:0] reload_count;
    logic        periodic;
    logic [15:0] job_tag;
  } request_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] fired_tag;
    logic [31:0] fire_sequence;
    logic        last;
  } result_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;   // take the neighbor's entry
    logic insert;  // the cell addressed by the insert index takes the new entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/octt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One timer slot: holds an entry, takes the next cell's entry on shift, or the
// broadcast entry when its own index is addressed.
module octt_cell
  import octt_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned IDX_BITS   = 5,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                  clk_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [IDX_BITS-1:0]   ins_idx_i,
  input  wire logic [COUNT_BITS-1:0] ins_cnt_i,
  input  wire logic [COUNT_BITS-1:0] ins_rld_i,
  input  wire logic                  ins_per_i,
  input  wire logic [15:0]           ins_tag_i,
  input  wire logic [COUNT_BITS-1:0] nxt_cnt_i,
  input  wire logic [COUNT_BITS-1:0] nxt_rld_i,
  input  wire logic                  nxt_per_i,
  input  wire logic [15:0]           nxt_tag_i,
  output logic      [COUNT_BITS-1:0] cnt_o,
  output logic      [COUNT_BITS-1:0] rld_o,
  output logic                       per_o,
  output logic      [15:0]           tag_o
);

  logic hit;

  assign hit = ctrl_i.insert && (ins_idx_i == IDX_BITS'(IDX));

  always_ff @(posedge clk_i) begin
    if (hit) begin
      cnt_o <= ins_cnt_i;
      rld_o <= ins_rld_i;
      per_o <= ins_per_i;
      tag_o <= ins_tag_i;
    end else if (ctrl_i.shift) begin
      cnt_o <= nxt_cnt_i;
      rld_o <= nxt_rld_i;
      per_o <= nxt_per_i;
      tag_o <= nxt_tag_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ordered_countdown_timer_table.sv =====
// Register transaction, or tick on an empty table: result in the cycle after
//   acceptance; busy stays low, so a new transaction may follow next cycle.
// Tick on a non-empty table: busy while the walk steps through every stored timer
//   as the chain shifts its head out, then through one flush step; last result is
//   registered out of the flush; at most one result per cycle, receiver cannot stall.
// Reset clears timer count, fire sequence and control; slots are written before read.
`timescale 1ns / 1ps
`default_nettype none

module ordered_countdown_timer_table
  import octt_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 32,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t req_i,
  output logic          res_valid_o,
  output result_t       res_o
);

  localparam int unsigned IDX_BITS = $clog2(TIMER_SLOTS);
  localparam int unsigned OCC_BITS = $clog2(TIMER_SLOTS + 1);

  // Chain of slots; slot 0 is the oldest timer and the head of the walk.
  logic [COUNT_BITS-1:0] cnt_w [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] rld_w [TIMER_SLOTS];
  logic                  per_w [TIMER_SLOTS];
  logic [15:0]           tag_w [TIMER_SLOTS];

  cell_ctrl_t            ctrl;
  logic [IDX_BITS-1:0]   ins_idx;
  logic [COUNT_BITS-1:0] ins_cnt;
  logic [COUNT_BITS-1:0] ins_rld;
  logic                  ins_per;
  logic [15:0]           ins_tag;

  // Control state
  state_e              state_q, state_d;
  logic [OCC_BITS-1:0] occ_q, occ_d;     // timers in the table
  logic [OCC_BITS-1:0] rem_q, rem_d;     // timers still to walk this tick
  logic [OCC_BITS-1:0] kept_q, kept_d;   // timers kept so far this tick
  logic [IDX_BITS-1:0] wr_idx_q, wr_idx_d;
  logic [31:0]         seq_q, seq_d;
  logic                pend_vld_q, pend_vld_d;
  logic [15:0]         pend_tag_q, pend_tag_d;
  logic [31:0]         pend_seq_q, pend_seq_d;
  logic                res_valid_d;
  result_t             res_d;

  logic accept;
  logic full;
  logic head_fire;
  logic head_keep;

  assign accept    = start && !busy;
  assign full      = (occ_q == OCC_BITS'(TIMER_SLOTS));
  assign head_fire = (cnt_w[0] == '0);
  assign head_keep = !head_fire || per_w[0];

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    if (g == TIMER_SLOTS - 1) begin : g_tail
      // Nothing beyond the tail: feed the broadcast entry, its value is unused.
      octt_cell #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IDX_BITS),
        .IDX        (g)
      ) u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .ins_idx_i (ins_idx),
        .ins_cnt_i (ins_cnt),
        .ins_rld_i (ins_rld),
        .ins_per_i (ins_per),
        .ins_tag_i (ins_tag),
        .nxt_cnt_i (ins_cnt),
        .nxt_rld_i (ins_rld),
        .nxt_per_i (ins_per),
        .nxt_tag_i (ins_tag),
        .cnt_o     (cnt_w[g]),
        .rld_o     (rld_w[g]),
        .per_o     (per_w[g]),
        .tag_o     (tag_w[g])
      );
    end else begin : g_body
      octt_cell #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IDX_BITS),
        .IDX        (g)
      ) u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .ins_idx_i (ins_idx),
        .ins_cnt_i (ins_cnt),
        .ins_rld_i (ins_rld),
        .ins_per_i (ins_per),
        .ins_tag_i (ins_tag),
        .nxt_cnt_i (cnt_w[g+1]),
        .nxt_rld_i (rld_w[g+1]),
        .nxt_per_i (per_w[g+1]),
        .nxt_tag_i (tag_w[g+1]),
        .cnt_o     (cnt_w[g]),
        .rld_o     (rld_w[g]),
        .per_o     (per_w[g]),
        .tag_o     (tag_w[g])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      rem_q       <= '0;
      kept_q      <= '0;
      wr_idx_q    <= '0;
      seq_q       <= '0;
      pend_vld_q  <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rem_q       <= rem_d;
      kept_q      <= kept_d;
      wr_idx_q    <= wr_idx_d;
      seq_q       <= seq_d;
      pend_vld_q  <= pend_vld_d;
      res_valid_o <= res_valid_d;
    end
  end

  // Result payload and pending firing hold no reset.
  always_ff @(posedge clk_i) begin
    res_o      <= res_d;
    pend_tag_q <= pend_tag_d;
    pend_seq_q <= pend_seq_d;
  end

  assign busy = (state_q != ST_IDLE);

  // A tick pops the head each cycle while the chain shifts toward it. A kept
  // timer is written back behind the timers not yet walked, at wr_idx; that
  // slot drops by one per step and holds still when a timer is kept, so the
  // survivors end up packed from slot 0 in their old order. A firing is held
  // until the next firing or flush so its last flag is known as it leaves.
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    rem_d       = rem_q;
    kept_d      = kept_q;
    wr_idx_d    = wr_idx_q;
    seq_d       = seq_q;
    pend_vld_d  = pend_vld_q;
    pend_tag_d  = pend_tag_q;
    pend_seq_d  = pend_seq_q;
    res_valid_d = 1'b0;
    res_d       = '{kind: KIND_NONE, fired_tag: '0, fire_sequence: '0, last: 1'b1};

    ctrl.shift  = 1'b0;
    ctrl.insert = 1'b0;
    ins_idx     = occ_q[IDX_BITS-1:0];
    ins_cnt     = COUNT_BITS'(req_i.start_count);
    ins_rld     = COUNT_BITS'(req_i.reload_count);
    ins_per     = req_i.periodic;
    ins_tag     = req_i.job_tag;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          if (req_i.operation == OP_REGISTER) begin
            if (full) begin
              res_d.kind = KIND_FULL;
            end else begin
              // Append at the tail of the table.
              res_d.kind  = KIND_REGISTERED;
              ctrl.insert = 1'b1;
              occ_d       = occ_q + OCC_BITS'(1);
            end
          end else if (occ_q == '0) begin
            res_d.kind = KIND_NONE;
          end else begin
            res_valid_d = 1'b0;
            state_d     = ST_WALK;
            rem_d       = occ_q;
            kept_d      = '0;
            wr_idx_d    = IDX_BITS'(occ_q - OCC_BITS'(1));
            pend_vld_d  = 1'b0;
          end
        end
      end

      ST_WALK: begin
        ctrl.shift  = 1'b1;
        ctrl.insert = head_keep;
        ins_idx     = wr_idx_q;
        ins_cnt     = head_fire ? rld_w[0] : cnt_w[0] - COUNT_BITS'(1);
        ins_rld     = rld_w[0];
        ins_per     = per_w[0];
        ins_tag     = tag_w[0];
        if (head_fire) begin
          // Release the previous firing, hold this one.
          if (pend_vld_q) begin
            res_valid_d = 1'b1;
            res_d       = '{kind: KIND_FIRED, fired_tag: pend_tag_q,
                            fire_sequence: pend_seq_q, last: 1'b0};
          end
          pend_vld_d = 1'b1;
          pend_tag_d = tag_w[0];
          pend_seq_d = seq_q;
          seq_d      = seq_q + 32'd1;
        end
        if (head_keep) begin
          kept_d = kept_q + OCC_BITS'(1);
        end else begin
          wr_idx_d = wr_idx_q - IDX_BITS'(1);
        end
        rem_d = rem_q - OCC_BITS'(1);
        if (rem_q == OCC_BITS'(1)) begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        // Close the tick: last firing, or a single none result.
        res_valid_d = 1'b1;
        if (pend_vld_q) begin
          res_d = '{kind: KIND_FIRED, fired_tag: pend_tag_q,
                    fire_sequence: pend_seq_q, last: 1'b1};
        end
        pend_vld_d = 1'b0;
        occ_d      = kept_q;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Table never holds more timers than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_BITS'(TIMER_SLOTS))
    else $error("timer count exceeds slot count");

  // During a walk, kept plus still-to-walk never exceeds the starting count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |->
      ((OCC_BITS+1)'(kept_q) + (OCC_BITS+1)'(rem_q) <= (OCC_BITS+1)'(occ_q)))
    else $error("walk bookkeeping out of range");

  // A register transaction answers in the next cycle with a single result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.operation == OP_REGISTER)) |=> (res_valid_o && res_o.last))
    else $error("register transaction gave no final result");

  // Only firings may be followed by further results of the same tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind != KIND_FIRED)) |-> res_o.last)
    else $error("non-fired result not marked last");

  // Walking ends in the flush step after the final timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && rem_q == OCC_BITS'(1)) |=> (state_q == ST_FLUSH))
    else $error("walk did not end in flush");

endmodule

`default_nettype wire

// ===== tb/sv/ordered_countdown_timer_table_checker.sv =====
`timescale 1ns / 1ps

module ordered_countdown_timer_table_checker
  import octt_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     busy_i,
  input  wire request_t req_i,
  input  wire logic     res_valid_i,
  input  wire result_t  res_i,
  output int unsigned   error_count_o,
  output int unsigned   pending_o,
  output int unsigned   accepted_o,
  output int unsigned   fires_o,
  output int unsigned   full_rejects_o,
  output int unsigned   peak_fires_o
);

  // Shadow copy of the timer table, oldest timer in slot 0.
  logic [15:0] timer_count    [TIMER_SLOTS];
  logic [15:0] timer_reload   [TIMER_SLOTS];
  logic        timer_periodic [TIMER_SLOTS];
  logic [15:0] timer_tag      [TIMER_SLOTS];
  int unsigned timer_total;
  logic [31:0] fire_seq;

  result_t due_results[$];

  // Append one predicted result at the back of the queue.
  task automatic add_due(input result_t r);
    due_results = {due_results, r};
  endtask

  task automatic register_timer(input request_t r);
    if (timer_total >= TIMER_SLOTS) begin
      add_due('{kind: KIND_FULL, fired_tag: 16'h0, fire_sequence: 32'h0, last: 1'b1});
      full_rejects_o++;
    end else begin
      timer_count[timer_total]    = r.start_count;
      timer_reload[timer_total]   = r.reload_count;
      timer_periodic[timer_total] = r.periodic;
      timer_tag[timer_total]      = r.job_tag;
      timer_total++;
      add_due('{kind: KIND_REGISTERED, fired_tag: 16'h0, fire_sequence: 32'h0,
                last: 1'b1});
    end
  endtask

  // Walk oldest to newest; compact survivors in place. Hold back the latest firing
  // so that it can carry the last flag once the walk is over.
  task automatic run_tick();
    int unsigned kept;
    int unsigned fired;
    logic        drop;
    logic        holding;
    result_t     held;
    kept    = 0;
    fired   = 0;
    holding = 1'b0;
    held    = '0;
    for (int unsigned slot = 0; slot < timer_total; slot++) begin
      drop = 1'b0;
      if (timer_count[slot] == 16'h0) begin
        if (holding) add_due(held);
        held = '{kind: KIND_FIRED, fired_tag: timer_tag[slot], fire_sequence: fire_seq,
                 last: 1'b0};
        holding = 1'b1;
        fire_seq++;
        fired++;
        if (timer_periodic[slot]) timer_count[slot] = timer_reload[slot];
        else drop = 1'b1;
      end else begin
        timer_count[slot]--;
      end
      if (!drop) begin
        timer_count[kept]    = timer_count[slot];
        timer_reload[kept]   = timer_reload[slot];
        timer_periodic[kept] = timer_periodic[slot];
        timer_tag[kept]      = timer_tag[slot];
        kept++;
      end
    end
    timer_total = kept;
    if (holding) begin
      held.last = 1'b1;
      add_due(held);
    end else begin
      add_due('{kind: KIND_NONE, fired_tag: 16'h0, fire_sequence: 32'h0, last: 1'b1});
    end
    fires_o += fired;
    if (fired > peak_fires_o) peak_fires_o = fired;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      if (error_count_o < 10)
        $display("%0t: unexpected result kind=%0d tag=%h seq=%h last=%b", $realtime,
                 got.kind, got.fired_tag, got.fire_sequence, got.last);
      error_count_o++;
    end else begin
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.fired_tag !== want.fired_tag ||
          got.fire_sequence !== want.fire_sequence || got.last !== want.last) begin
        if (error_count_o < 10)
          $display({"%0t: mismatch exp kind=%0d tag=%h seq=%h last=%b,",
                    " got kind=%0d tag=%h seq=%h last=%b"},
                   $realtime, want.kind, want.fired_tag, want.fire_sequence, want.last,
                   got.kind, got.fired_tag, got.fire_sequence, got.last);
        error_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_total = 0;
      fire_seq    = 32'h0;
      due_results.delete();
      error_count_o  = 0;
      pending_o      = 0;
      accepted_o     = 0;
      fires_o        = 0;
      full_rejects_o = 0;
      peak_fires_o   = 0;
    end else begin
      if (res_valid_i) check_result(res_i);
      if (start_i && !busy_i) begin
        accepted_o++;
        if (req_i.operation == OP_TICK) run_tick();
        else register_timer(req_i);
      end
      pending_o = due_results.size();
    end
  end

endmodule

// ===== tb/sv/ordered_countdown_timer_table_tb.sv =====
`timescale 1ns / 1ps

module ordered_countdown_timer_table_tb;
  import octt_pkg::*;

  localparam int unsigned TIMER_SLOTS  = 32;
  // A tick keeps the block busy while it walks each timer and then flushes, and
  // its last result follows in the next cycle; leave some margin on top.
  localparam int unsigned DRAIN_CYCLES = TIMER_SLOTS + 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  request_t    req;
  logic        res_valid;
  result_t     res;

  int unsigned idle_pct;
  int unsigned cycle_count = 0;

  int unsigned error_count;
  int unsigned pending;
  int unsigned accepted;
  int unsigned fires;
  int unsigned full_rejects;
  int unsigned peak_fires;

  always #6 clk = ~clk;

  ordered_countdown_timer_table #(
    .TIMER_SLOTS(TIMER_SLOTS),
    .COUNT_BITS (16)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  ordered_countdown_timer_table_checker #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .error_count_o (error_count),
    .pending_o     (pending),
    .accepted_o    (accepted),
    .fires_o       (fires),
    .full_rejects_o(full_rejects),
    .peak_fires_o  (peak_fires)
  );

  // Abort a hung run: a stuck busy or a missing result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic request_t timer_req(input logic [15:0] start_cnt,
                                         input logic [15:0] reload_cnt,
                                         input logic        repeat_it,
                                         input logic [15:0] tag);
    request_t r;
    r.operation    = OP_REGISTER;
    r.start_count  = start_cnt;
    r.reload_count = reload_cnt;
    r.periodic     = repeat_it;
    r.job_tag      = tag;
    return r;
  endfunction

  // The block ignores every field but the operation on a tick; fill them with
  // noise anyway so that no stale payload can leak into the walk.
  function automatic request_t tick_req();
    request_t r;
    r.operation    = OP_TICK;
    r.start_count  = 16'($urandom);
    r.reload_count = 16'($urandom);
    r.periodic     = 1'($urandom);
    r.job_tag      = 16'($urandom);
    return r;
  endfunction

  // Keep most counts tiny so timers actually expire within the run; allow the
  // full 16-bit range only when asked, since such a timer never leaves again.
  function automatic logic [15:0] pick_count(input bit wide);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (wide && roll < 20) return 16'($urandom);
    if (roll < 70) return 16'($urandom_range(0, 3));
    return 16'($urandom_range(0, 15));
  endfunction

  // Drive one transaction: idle at random first, then present it at a falling
  // edge and hold it until a rising edge sees busy low.
  task automatic issue(input request_t r);
    while ($urandom_range(1, 100) <= idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold off until every predicted result has come back.
  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly registrations with few periodic timers, so the table churns instead
  // of clogging with timers that never leave.
  task automatic random_items(input int unsigned n, input bit wide);
    repeat (n) begin
      if ($urandom_range(0, 99) < 40) issue(tick_req());
      else issue(timer_req(pick_count(wide), pick_count(wide),
                           1'($urandom_range(0, 99) < 12), 16'($urandom)));
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    req      = '0;
    idle_pct = 37;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Tick on an empty table: a single none-fired result.
    issue(tick_req());
    // One-shot at zero with a reload that must be ignored; it leaves on the first tick.
    issue(timer_req(16'h0000, 16'hFFFF, 1'b0, 16'hFFFF));
    // Periodic with reload zero: fires on every tick, for the rest of the run.
    issue(timer_req(16'h0000, 16'h0000, 1'b1, 16'h0000));
    // Periodic reload of two: after firing it must not count down on the same tick.
    issue(timer_req(16'h0000, 16'h0002, 1'b1, 16'h1234));
    issue(timer_req(16'h0003, 16'h0000, 1'b0, 16'h8001));
    issue(timer_req(16'h0001, 16'h5555, 1'b0, 16'h7FFE));
    issue(tick_req());
    issue(tick_req());
    // One-shot behind older timers: it leaves on the next tick, the rest keep order.
    issue(timer_req(16'h0000, 16'hAAAA, 1'b0, 16'h5A5A));
    issue(tick_req());
    // Three timers left, all at zero now.
    wait_quiet();

    // Fill the table with one-shots at zero, then knock on the full table twice,
    // once with every field at its top value. The next tick fires all 32 slots.
    repeat (TIMER_SLOTS - 3) issue(timer_req(16'h0000, 16'($urandom), 1'b0, 16'($urandom)));
    issue(timer_req(16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF));
    issue(timer_req(16'h0000, 16'h0000, 1'b0, 16'h0000));
    issue(tick_req());
    wait_quiet();

    // Random traffic: light sender idling, then heavy, then back to back with
    // full-range counts allowed.
    random_items(40, 1'b0);
    wait_quiet();
    idle_pct = 84;
    random_items(40, 1'b0);
    wait_quiet();
    idle_pct = 0;
    random_items(40, 1'b1);

    wait_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d transactions: %0d timer firings (up to %0d in one tick),",
             accepted, fires, peak_fires);
    $display("  %0d full-table rejects, under light, heavy and no sender idling.",
             full_rejects);
    if (error_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== ordered_countdown_timer_table.f =====
rtl/core/octt_pkg.sv
rtl/core/octt_cell.sv
rtl/core/ordered_countdown_timer_table.sv
tb/sv/ordered_countdown_timer_table_checker.sv
tb/sv/ordered_countdown_timer_table_tb.sv
